>>> rtl/rapg_pkg.sv
// Shared types and constants of the relay autotune PID gain block.
package rapg_pkg;

  localparam int FUNC_W = 2;
  localparam int TEMP_W = 8;
  localparam int TIME_W = 32;
  localparam int GAIN_W = 32;
  localparam int IN_DW  = 40;
  localparam int OUT_DW = 104;

  localparam logic [FUNC_W-1:0] FN_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SAMPLE = 2'd2;

  localparam logic [1:0] STG_IDLE = 2'd0;
  localparam logic [1:0] STG_RUN  = 2'd1;
  localparam logic [1:0] STG_DONE = 2'd2;

  localparam logic [GAIN_W-1:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [TEMP_W-1:0] temperature;
  } in_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_p;
    logic [2:0]        cycles_seen;
    logic              done_now;
    logic [1:0]        stage;
  } res_t;

endpackage

>>> rtl/relay_autotune_pid_gains.sv
// Relay autotune: peak/trough tracking and Ziegler-Nichols no-overshoot gains.
// An item that does not finish the tuning passes the hold and output registers; one
// item per cycle unless stalled. The finishing item blocks input while the 32-step
// bit-serial multiplier and restoring divider run in turn, up to twice and thrice.
// Reset (rst, synchronous): idle, gains zero, output channel empty.
module relay_autotune_pid_gains
  import rapg_pkg::*;
#(
  parameter int CYCLES_FOR_RESULT = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // temperature, time_ms
  input  logic [FUNC_W-1:0] s_tuser,   // func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata    // stage, done_now, cycles_seen, gain_p, gain_i, gain_d
);

  localparam int N      = CYCLES_FOR_RESULT;
  localparam int N1     = N - 1;
  localparam int CW     = ($clog2(N + 1) > 3) ? $clog2(N + 1) : 3;
  localparam int AW     = 10 + $clog2(N);
  localparam int PW     = 32 + $clog2(N);
  localparam int NW     = PW + 38;
  localparam int HW     = NW - 32;
  localparam int STEPS  = 32;
  localparam int SW     = $clog2(STEPS);

  localparam logic [NW-1:0] K1     = NW'((64'd524288000000 * N1) / 64'd314159);
  localparam logic [NW-1:0] KI_MUL = NW'(2000 * N1);
  localparam logic [PW-1:0] KD_DEN = PW'(100000 * N1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_KP   = 4'd1;
  localparam logic [3:0] ST_KI   = 4'd2;
  localparam logic [3:0] ST_KD   = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_MULX = 4'd5;
  localparam logic [3:0] ST_DIVS = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  localparam logic [1:0] PH_P = 2'd0;
  localparam logic [1:0] PH_I = 2'd1;
  localparam logic [1:0] PH_D = 2'd2;

  logic [3:0]             st;
  logic [1:0]             phase;
  logic [SW-1:0]          cnt;

  logic [1:0]             run_stage, run_stage_next;
  logic [CW-1:0]          count, count_next, count_inc;
  logic                   rising, rising_next;
  logic signed [9:0]      running_max, running_max_next;
  logic signed [9:0]      running_min, running_min_next;
  logic signed [9:0]      peak_hold, peak_hold_next;
  logic [TEMP_W-1:0]      previous_temp, previous_temp_next;
  logic [TIME_W-1:0]      last_stamp, last_stamp_next;
  logic signed [AW-1:0]   sum_a, sum_a_next;
  logic [PW-1:0]          sum_p, sum_p_next;

  logic [GAIN_W-1:0]      gain_p, gain_i, gain_d;

  logic [NW-1:0]          acc, mcand;
  logic [31:0]            mplier;
  logic [HW-1:0]          rem;
  logic [31:0]            num_lo;
  logic [PW-1:0]          den;
  logic [31:0]            quo;

  logic                   hold_valid;
  res_t                   hold_q, out_q, snap;

  in_t                    in_d;
  logic [FUNC_W-1:0]      func;
  logic                   accept, move, finish;
  logic                   detect, peak_ev, trough_ev;
  logic signed [9:0]      t_s, max_base, min_base;
  logic signed [10:0]     amp;
  logic [TIME_W-1:0]      stamp_diff;
  logic [HW-1:0]          trial;
  logic                   div_ge, div_sat, div_done, cnt_last;
  logic [31:0]            div_val;

  assign in_d     = s_tdata;
  assign func     = s_tuser;
  assign move     = hold_valid && (!m_tvalid || m_tready);
  assign s_tready = (st == ST_IDLE) && (!hold_valid || move);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = out_q;

  assign t_s        = $signed({2'b00, in_d.temperature});
  assign detect     = (func == FN_SAMPLE) && (run_stage == STG_RUN) && (previous_temp != '0);
  assign peak_ev    = detect && rising && (in_d.temperature < previous_temp);
  assign trough_ev  = detect && !rising && (in_d.temperature > previous_temp);
  assign count_inc  = count + 1'b1;
  assign finish     = trough_ev && (count_inc == CW'(N));
  assign amp        = {peak_hold[9], peak_hold} - {running_min[9], running_min};
  assign stamp_diff = in_d.time_ms - last_stamp;

  always_comb begin
    run_stage_next     = run_stage;
    count_next         = count;
    rising_next        = rising;
    running_max_next   = running_max;
    running_min_next   = running_min;
    peak_hold_next     = peak_hold;
    previous_temp_next = previous_temp;
    last_stamp_next    = last_stamp;
    sum_a_next         = sum_a;
    sum_p_next         = sum_p;
    max_base           = trough_ev ? t_s : running_max;
    min_base           = peak_ev ? t_s : running_min;
    case (func)
      FN_START: begin
        run_stage_next   = STG_RUN;
        count_next       = '0;
        rising_next      = 1'b1;
        running_max_next = -10'sd1;
        running_min_next = 10'sd200;
        sum_a_next       = '0;
        sum_p_next       = '0;
      end
      FN_CANCEL: begin
        run_stage_next = STG_IDLE;
      end
      FN_SAMPLE: begin
        if (run_stage == STG_RUN) begin
          if (peak_ev) begin
            rising_next     = 1'b0;
            peak_hold_next  = running_max;
            last_stamp_next = in_d.time_ms;
            if (count != '0) begin
              sum_p_next = sum_p + PW'(stamp_diff);
            end
          end
          if (trough_ev) begin
            rising_next = 1'b1;
            count_next  = count_inc;
            if (count != '0) begin
              sum_a_next = sum_a + AW'(amp);
            end
            if (finish) begin
              run_stage_next = STG_DONE;
            end
          end
          running_max_next   = (t_s > max_base) ? t_s : max_base;
          running_min_next   = (t_s < min_base) ? t_s : min_base;
          previous_temp_next = in_d.temperature;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    snap             = '0;
    snap.gain_p      = gain_p;
    snap.gain_i      = gain_i;
    snap.gain_d      = gain_d;
    if (st == ST_FIN) begin
      snap.stage       = run_stage;
      snap.done_now    = 1'b1;
      snap.cycles_seen = count[2:0];
    end else begin
      snap.stage       = run_stage_next;
      snap.done_now    = 1'b0;
      snap.cycles_seen = count_next[2:0];
    end
  end

  assign trial    = {rem[HW-2:0], num_lo[31]};
  assign div_ge   = trial >= HW'(den);
  assign div_sat  = rem >= HW'(den);
  assign cnt_last = cnt == SW'(STEPS - 1);
  assign div_done = ((st == ST_DIVS) && div_sat) || ((st == ST_DIV) && cnt_last);
  assign div_val  = (st == ST_DIVS) ? SAT32 : {quo[30:0], div_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      run_stage     <= STG_IDLE;
      count         <= '0;
      rising        <= 1'b1;
      running_max   <= -10'sd1;
      running_min   <= 10'sd200;
      previous_temp <= '0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      hold_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        run_stage     <= run_stage_next;
        count         <= count_next;
        rising        <= rising_next;
        running_max   <= running_max_next;
        running_min   <= running_min_next;
        peak_hold     <= peak_hold_next;
        previous_temp <= previous_temp_next;
        last_stamp    <= last_stamp_next;
        sum_a         <= sum_a_next;
        sum_p         <= sum_p_next;
      end

      if ((accept && !finish) || (st == ST_FIN)) begin
        hold_q     <= snap;
        hold_valid <= 1'b1;
      end else if (move) begin
        hold_valid <= 1'b0;
      end

      if (move) begin
        out_q    <= hold_q;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (st)
        ST_IDLE: begin
          if (accept && finish) begin
            st <= ST_KP;
          end
        end
        ST_KP: begin
          if (sum_a == '0) begin
            gain_p <= SAT32;
            st     <= ST_KI;
          end else if (sum_a[AW-1]) begin
            gain_p <= '0;
            st     <= ST_KI;
          end else begin
            rem    <= K1[NW-1:32];
            num_lo <= K1[31:0];
            den    <= PW'($unsigned(sum_a));
            phase  <= PH_P;
            st     <= ST_DIVS;
          end
        end
        ST_KI: begin
          if (sum_p == '0) begin
            gain_i <= (gain_p != '0) ? SAT32 : '0;
            st     <= ST_KD;
          end else begin
            acc    <= '0;
            mcand  <= KI_MUL;
            mplier <= gain_p;
            cnt    <= '0;
            phase  <= PH_I;
            st     <= ST_MUL;
          end
        end
        ST_KD: begin
          acc    <= '0;
          mcand  <= (NW'(sum_p) << 5) + NW'(sum_p);
          mplier <= gain_p;
          cnt    <= '0;
          phase  <= PH_D;
          st     <= ST_MUL;
        end
        ST_MUL: begin
          acc    <= (acc << 1) + (mplier[31] ? mcand : '0);
          mplier <= mplier << 1;
          cnt    <= cnt + 1'b1;
          if (cnt_last) begin
            st <= ST_MULX;
          end
        end
        ST_MULX: begin
          rem    <= acc[NW-1:32];
          num_lo <= acc[31:0];
          den    <= (phase == PH_I) ? sum_p : KD_DEN;
          st     <= ST_DIVS;
        end
        ST_DIVS: begin
          if (!div_sat) begin
            cnt <= '0;
            st  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem    <= div_ge ? (trial - HW'(den)) : trial;
          num_lo <= num_lo << 1;
          quo    <= {quo[30:0], div_ge};
          cnt    <= cnt + 1'b1;
        end
        ST_FIN: begin
          st <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase

      if (div_done) begin
        case (phase)
          PH_P: begin
            gain_p <= div_val;
            st     <= ST_KI;
          end
          PH_I: begin
            gain_i <= div_val;
            st     <= ST_KD;
          end
          default: begin
            gain_d <= div_val;
            st     <= ST_FIN;
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/rapg_checker.sv
// Port-level checks of the relay autotune block, bound to its top level.
module rapg_checker
  import rapg_pkg::*;
#(
  parameter int CYCLES_FOR_RESULT = 4
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_DW-1:0] m_tdata    // stage, done_now, cycles_seen, gain_p, gain_i, gain_d
);

  logic [1:0] outstanding;
  logic       in_acc, out_acc;
  res_t       res;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign res     = m_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  // transaction payload holds under a stall
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result without an accepted item behind it
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> outstanding != 2'd0)
    else $error("result with no pending item");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    outstanding == 2'd2 && !m_tready |-> !s_tready)
    else $error("input taken with both result slots full");

  a_done_stage: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.done_now |->
      res.stage == STG_DONE && res.cycles_seen == 3'(CYCLES_FOR_RESULT))
    else $error("completion flagged in wrong stage or cycle count");

endmodule

bind relay_autotune_pid_gains rapg_checker #(
  .CYCLES_FOR_RESULT(CYCLES_FOR_RESULT)
) u_rapg_checker (.*);
